// File: hdl/mqtt_fixed_header_parser_macros.svh
// ============================================================================
// mqtt_fixed_header_parser_macros.svh
// Assertion macros shared by the fixed-header parser modules.
// ============================================================================
`ifndef MQTT_FIXED_HEADER_PARSER_MACROS_SVH
`define MQTT_FIXED_HEADER_PARSER_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define MFHP_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define MFHP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MFHP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mfhp_pkg.sv
// ============================================================================
// mfhp_pkg
// Types and constants of the MQTT fixed-header parser.
// ============================================================================
package mfhp_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int NIB_W  = 4;
    localparam int LEN_W  = 28;
    localparam int MASK_W = 16;
    localparam int GRP_W  = 7;

    // Defaults
    localparam int              MAX_LENGTH_GROUPS_DEF = 4;
    localparam logic [MASK_W-1:0] MASK_RESET          = 16'h55FA;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNKNOWN   = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_CLOSED    = 2'd3
    } status_t;

    // Parser phase, one-hot
    typedef enum logic [1:0] {
        PH_CTRL = 2'b01,
        PH_LEN  = 2'b10
    } phase_t;

    // One input beat
    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              closed;
    } in_beat_t;

    // One result beat
    typedef struct packed {
        logic [NIB_W-1:0] packet_type;
        logic [NIB_W-1:0] packet_flags;
        logic [LEN_W-1:0] rem_len;
        status_t          status;
    } result_t;

endpackage

// File: hdl/mfhp_in_reg.sv
// ============================================================================
// mfhp_in_reg
// Input register: captures one stream beat, releases it to the decoder.
// ============================================================================
module mfhp_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  mfhp_pkg::in_beat_t s_beat,
    output logic               beat_valid,
    output mfhp_pkg::in_beat_t beat,
    input  logic               beat_take
);

    logic               valid_reg;
    logic               valid_next;
    mfhp_pkg::in_beat_t beat_reg;

    // Free slot, or the held beat leaves this cycle
    assign s_tready = !valid_reg || beat_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            beat_reg <= s_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// File: hdl/mfhp_decode.sv
// ============================================================================
// mfhp_decode
// Header decoder: control byte check, base-128 length accumulation, errors.
// ============================================================================
`include "mqtt_fixed_header_parser_macros.svh"

module mfhp_decode #(
    parameter int MAX_LENGTH_GROUPS = mfhp_pkg::MAX_LENGTH_GROUPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          take,
    input  mfhp_pkg::in_beat_t            beat,
    input  logic [mfhp_pkg::MASK_W-1:0]   type_mask,
    output logic                          res_valid,
    output mfhp_pkg::result_t             res
);

    localparam int CNT_W = (MAX_LENGTH_GROUPS > 1) ? $clog2(MAX_LENGTH_GROUPS) : 1;
    localparam int SH_W  = CNT_W + 3;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_LENGTH_GROUPS - 1);

    mfhp_pkg::phase_t             phase_reg,  phase_next;
    logic [mfhp_pkg::NIB_W-1:0]   type_reg,   type_next;
    logic [mfhp_pkg::NIB_W-1:0]   flags_reg,  flags_next;
    logic [mfhp_pkg::LEN_W-1:0]   len_reg,    len_next;
    logic [CNT_W-1:0]             cnt_reg,    cnt_next;

    logic [SH_W-1:0]              shamt;
    logic [mfhp_pkg::LEN_W-1:0]   part;
    logic [mfhp_pkg::LEN_W-1:0]   sum;
    logic [mfhp_pkg::NIB_W-1:0]   byte_type;
    logic [mfhp_pkg::NIB_W-1:0]   byte_flags;

    // Group n lands at bit 7*n; bits above the length field drop off
    assign shamt      = {cnt_reg, 3'b000} - SH_W'(cnt_reg);
    assign part       = mfhp_pkg::LEN_W'(beat.byte_value[mfhp_pkg::GRP_W-1:0]) << shamt;
    assign sum        = len_reg + part;
    assign byte_type  = beat.byte_value[mfhp_pkg::BYTE_W-1:mfhp_pkg::NIB_W];
    assign byte_flags = beat.byte_value[mfhp_pkg::NIB_W-1:0];

    // Next state and result
    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        flags_next = flags_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        res_valid  = 1'b0;
        res.packet_type  = type_reg;
        res.packet_flags = flags_reg;
        res.rem_len      = '0;
        res.status       = mfhp_pkg::ST_OK;
        case (phase_reg)
            mfhp_pkg::PH_CTRL: begin
                if (take && !beat.closed) begin
                    if (!type_mask[byte_type]) begin
                        res_valid        = 1'b1;
                        res.packet_type  = byte_type;
                        res.packet_flags = byte_flags;
                        res.status       = mfhp_pkg::ST_UNKNOWN;
                    end else begin
                        type_next  = byte_type;
                        flags_next = byte_flags;
                        len_next   = '0;
                        cnt_next   = '0;
                        phase_next = mfhp_pkg::PH_LEN;
                    end
                end
            end
            mfhp_pkg::PH_LEN: begin
                if (take) begin
                    if (beat.closed) begin
                        res_valid  = 1'b1;
                        res.status = mfhp_pkg::ST_CLOSED;
                        phase_next = mfhp_pkg::PH_CTRL;
                    end else if (!beat.byte_value[mfhp_pkg::BYTE_W-1]) begin
                        res_valid   = 1'b1;
                        res.rem_len = sum;
                        len_next    = sum;
                        phase_next  = mfhp_pkg::PH_CTRL;
                    end else if (cnt_reg == CNT_LAST) begin
                        res_valid  = 1'b1;
                        res.status = mfhp_pkg::ST_MALFORMED;
                        len_next   = sum;
                        phase_next = mfhp_pkg::PH_CTRL;
                    end else begin
                        len_next = sum;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                phase_next = mfhp_pkg::PH_CTRL;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mfhp_pkg::PH_CTRL;
            cnt_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Header payload, no reset
    always_ff @(posedge aclk) begin
        type_reg  <= type_next;
        flags_reg <= flags_next;
        len_reg   <= len_next;
    end

    // Checks
    `MFHP_ASSERT_ALWAYS(a_cnt_range, aclk, aresetn, cnt_reg <= CNT_LAST,
        "group count overrun")
    `MFHP_ASSERT_IMP(a_ok_from_len, aclk, aresetn,
        res_valid && res.status == mfhp_pkg::ST_OK, phase_reg == mfhp_pkg::PH_LEN,
        "ok result outside length phase")
    `MFHP_ASSERT_IMP(a_ctrl_unknown, aclk, aresetn,
        res_valid && phase_reg == mfhp_pkg::PH_CTRL, res.status == mfhp_pkg::ST_UNKNOWN,
        "control byte gave non-type error")
    `MFHP_ASSERT_NXT(a_back_to_ctrl, aclk, aresetn, res_valid,
        phase_reg == mfhp_pkg::PH_CTRL, "no return to control phase after result")

endmodule

// File: hdl/mfhp_out_reg.sv
// ============================================================================
// mfhp_out_reg
// Result register: holds one result beat until the receiver takes it.
// ============================================================================
module mfhp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  mfhp_pkg::result_t res,
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output mfhp_pkg::result_t m_res
);

    logic              valid_reg;
    logic              valid_next;
    mfhp_pkg::result_t res_reg;

    // Empty, or the held beat is taken this cycle
    assign can_load = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (can_load) begin
            valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (can_load && load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

// File: hdl/mqtt_fixed_header_parser.sv
// ============================================================================
// mqtt_fixed_header_parser
// Parses MQTT fixed headers from a byte stream into type, flags and length.
// ============================================================================
// Usage:
//   s_ channel: one received byte per beat; s_tuser high marks a connection
//   close (no byte). The first byte of a header is the control byte, then
//   up to MAX_LENGTH_GROUPS base-128 length bytes, least significant first.
//   m_ channel: one beat per finished or failed header; m_tuser carries the
//   status (ok, unknown type, malformed length, connection closed).
//   cfg_we/cfg_wdata write the accepted-type mask; bit n accepts type n.
// Timing:
//   One byte per cycle sustained while m_tready does not stall the result register.
//   m_tvalid rises once the beat ending a header has passed the input
//   register and then the result register.
//   Decode is a 28-bit shift-add and compare.
// Reset:
//   aresetn low empties both registers, returns to waiting for a control
//   byte and loads the mask with 0x55FA.
// Stall:
//   When m_tready is low and the result register is full, the decoder holds
//   its beat and s_tready drops once the input register is also full.
// ============================================================================
module mqtt_fixed_header_parser #(
    parameter int MAX_LENGTH_GROUPS = mfhp_pkg::MAX_LENGTH_GROUPS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] byte_value
    input  logic                        s_tuser,   // [0] closed
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,   // [3:0] packet_type, [7:4] packet_flags,
                                                   // [35:8] rem_len, [39:36] zero
    output logic [1:0]                  m_tuser,   // [1:0] status
    // Configuration
    input  logic                        cfg_we,
    input  logic [mfhp_pkg::MASK_W-1:0] cfg_wdata
);

    logic [mfhp_pkg::MASK_W-1:0] mask_reg;
    mfhp_pkg::in_beat_t          s_beat;
    mfhp_pkg::in_beat_t          beat;
    logic                        beat_valid;
    logic                        beat_take;
    logic                        can_load;
    logic                        res_valid;
    mfhp_pkg::result_t           res;
    mfhp_pkg::result_t           m_res;

    // Accepted-type mask
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= mfhp_pkg::MASK_RESET;
        end else if (cfg_we) begin
            mask_reg <= cfg_wdata;
        end
    end

    assign s_beat.byte_value = s_tdata;
    assign s_beat.closed     = s_tuser;

    // Decoder moves only when the result register can take its output
    assign beat_take = beat_valid && can_load;

    mfhp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_beat     (s_beat),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take)
    );

    mfhp_decode #(
        .MAX_LENGTH_GROUPS (MAX_LENGTH_GROUPS)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (beat_take),
        .beat      (beat),
        .type_mask (mask_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    mfhp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_valid),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    // Result packing
    assign m_tdata = {4'b0000, m_res.rem_len, m_res.packet_flags, m_res.packet_type};
    assign m_tuser = m_res.status;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for mqtt_fixed_header_parser
// A clocked driver sends received bytes and close events from a queue. A
// header decoder in the bench predicts every result beat from the accepted
// input beats. A clocked monitor compares each result beat with the oldest
// prediction. Both streams idle and stall at random, and the accepted-type
// mask is reloaded between phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LEN_GROUPS   = mfhp_pkg::MAX_LENGTH_GROUPS_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BEATS  = 70;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata   = '0;
    logic                          s_tuser   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [39:0]                   m_tdata;
    logic [1:0]                    m_tuser;
    logic                          cfg_we    = 1'b0;
    logic [mfhp_pkg::MASK_W-1:0]   cfg_wdata = '0;

    // Beats waiting to be sent and headers waiting to come out
    mfhp_pkg::in_beat_t  bytes_to_send[$];
    mfhp_pkg::result_t   headers_due[$];
    int        beats_queued = 0;
    int        mismatches   = 0;
    int        idle_pct     = 36;
    int        stall_pct    = 36;

    // Bench copy of the parser state and the mask
    logic [mfhp_pkg::MASK_W-1:0] type_mask   = mfhp_pkg::MASK_RESET;
    logic                        in_header   = 1'b0;
    logic [mfhp_pkg::NIB_W-1:0]  hdr_type    = '0;
    logic [mfhp_pkg::NIB_W-1:0]  hdr_flags   = '0;
    logic [mfhp_pkg::LEN_W-1:0]  len_acc     = '0;
    logic [2:0]                  grp_cnt     = '0;

    mqtt_fixed_header_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
                 got, want);
    endtask

    task automatic queue_header(input logic [mfhp_pkg::NIB_W-1:0] t,
                                input logic [mfhp_pkg::NIB_W-1:0] f,
                                input logic [mfhp_pkg::LEN_W-1:0] len,
                                input mfhp_pkg::status_t st);
        mfhp_pkg::result_t r;
        r.packet_type  = t;
        r.packet_flags = f;
        r.rem_len      = len;
        r.status       = st;
        headers_due.push_back(r);
    endtask

    // Header decoder: one accepted beat in, zero or one predicted result out
    task automatic decode_header_byte(input mfhp_pkg::in_beat_t beat);
        logic [mfhp_pkg::LEN_W-1:0] part;
        if (!in_header) begin
            // a close with no header open is dropped
            if (beat.closed)
                return;
            if (!type_mask[beat.byte_value[7:4]]) begin
                queue_header(beat.byte_value[7:4], beat.byte_value[3:0], '0,
                             mfhp_pkg::ST_UNKNOWN);
                return;
            end
            hdr_type  = beat.byte_value[7:4];
            hdr_flags = beat.byte_value[3:0];
            len_acc   = '0;
            grp_cnt   = '0;
            in_header = 1'b1;
            return;
        end
        if (beat.closed) begin
            queue_header(hdr_type, hdr_flags, '0, mfhp_pkg::ST_CLOSED);
            in_header = 1'b0;
            return;
        end
        part    = mfhp_pkg::LEN_W'(beat.byte_value[6:0]) << (mfhp_pkg::GRP_W * grp_cnt);
        len_acc = len_acc + part;
        if (!beat.byte_value[7]) begin
            queue_header(hdr_type, hdr_flags, len_acc, mfhp_pkg::ST_OK);
            in_header = 1'b0;
        end else if (int'(grp_cnt) + 1 >= LEN_GROUPS) begin
            // continuation still set on the last allowed group
            queue_header(hdr_type, hdr_flags, '0, mfhp_pkg::ST_MALFORMED);
            in_header = 1'b0;
        end else begin
            grp_cnt = grp_cnt + 3'd1;
        end
    endtask

    // Input driver
    always @(posedge aclk) begin : byte_driver
        mfhp_pkg::in_beat_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                decode_header_byte({s_tdata, s_tuser});
            if (!s_tvalid || s_tready) begin
                if (bytes_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    nxt = bytes_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.byte_value;
                    s_tuser  <= nxt.closed;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin : result_monitor
        mfhp_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (headers_due.size() == 0) begin
                    flag_mismatch("unexpected result beat", m_tdata[31:0], '0);
                end else begin
                    want = headers_due.pop_front();
                    if (m_tdata[3:0] != want.packet_type)
                        flag_mismatch("packet_type", 32'(m_tdata[3:0]),
                                      32'(want.packet_type));
                    if (m_tdata[7:4] != want.packet_flags)
                        flag_mismatch("packet_flags", 32'(m_tdata[7:4]),
                                      32'(want.packet_flags));
                    if (m_tdata[35:8] != want.rem_len)
                        flag_mismatch("rem_len", 32'(m_tdata[35:8]),
                                      32'(want.rem_len));
                    if (m_tdata[39:36] != '0)
                        flag_mismatch("tdata pad bits", 32'(m_tdata[39:36]), '0);
                    if (m_tuser != want.status)
                        flag_mismatch("status", 32'(m_tuser), 32'(want.status));
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic push_byte(input logic [7:0] b);
        bytes_to_send.push_back({b, 1'b0});
        beats_queued++;
    endtask

    task automatic push_close();
        bytes_to_send.push_back({8'($urandom), 1'b1});
        beats_queued++;
    endtask

    // Length bytes; open_end keeps the continuation bit on the last one too
    task automatic push_groups(input int n, input bit open_end);
        for (int i = 0; i < n; i++)
            push_byte({(i < n - 1) || open_end, 7'($urandom)});
    endtask

    // Mostly a type the current mask accepts, sometimes any type
    function automatic logic [7:0] pick_control_byte();
        logic [7:0] b;
        int         tries;
        b     = 8'($urandom);
        tries = 0;
        if (type_mask != '0 && $urandom_range(4) != 0) begin
            while (!type_mask[b[7:4]] && tries < 32) begin
                b = 8'($urandom);
                tries++;
            end
        end
        return b;
    endfunction

    task automatic queue_random_packet();
        int k;
        int r;
        k = $urandom_range(99);
        if (k < 58) begin
            // well-formed header, mostly short lengths
            push_byte(pick_control_byte());
            r = $urandom_range(9);
            push_groups(r < 4 ? 1 : r < 7 ? 2 : r < 9 ? 3 : LEN_GROUPS, 1'b0);
        end else if (k < 70) begin
            // connection drops mid-header
            push_byte(pick_control_byte());
            push_groups($urandom_range(LEN_GROUPS - 1), 1'b1);
            push_close();
        end else if (k < 78) begin
            // continuation never ends
            push_byte(pick_control_byte());
            push_groups(LEN_GROUPS, 1'b1);
        end else if (k < 86) begin
            push_close();
        end else begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(4) == 0)
                    push_close();
                else
                    push_byte(8'($urandom));
            end
        end
    endtask

    // Let every queued beat go and every result come out
    task automatic wait_quiet();
        while (bytes_to_send.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (headers_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_type_mask(input logic [mfhp_pkg::MASK_W-1:0] value);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        type_mask = value;
    endtask

    task automatic run_random_phase(input logic [mfhp_pkg::MASK_W-1:0] mask_value);
        int target;
        load_type_mask(mask_value);
        target = beats_queued + PHASE_BEATS;
        while (beats_queued < target)
            queue_random_packet();
    endtask

    // Stimulus
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part under the reset mask
        push_byte(8'h3F); push_byte(8'h00);                   // zero length
        push_byte(8'h00);                                     // type 0 rejected
        push_byte(8'hFF);                                     // type 15 rejected
        push_close();                                         // close while idle
        push_byte(8'h10);                                     // largest length
        push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'h7F);
        push_byte(8'h82);                                     // too many groups
        push_byte(8'h80); push_byte(8'h80); push_byte(8'h80); push_byte(8'h80);
        push_byte(8'h30); push_byte(8'h85); push_close();     // close mid-header
        push_byte(8'hE0); push_byte(8'h7F);                   // one group, 127
        push_byte(8'hC5); push_byte(8'h80); push_byte(8'h01); // non-minimal, 128
        push_byte(8'h6A); push_close();                       // close right after ctrl

        // long stretch with no idling on either side
        idle_pct  = 0;
        stall_pct = 0;
        run_random_phase(16'hFFFF);
        wait_quiet();
        idle_pct  = 36;
        stall_pct = 36;
        run_random_phase(16'h0000);
        run_random_phase(16'($urandom));
        run_random_phase(16'h8001);
        run_random_phase(16'($urandom));
        run_random_phase(mfhp_pkg::MASK_RESET);

        wait_quiet();
        if (mismatches == 0 && headers_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #(2_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
